// File: hw/rtl/cpw_pkg.sv
// shared types and constants for the circle-against-wall collision probe
// used by cpw_ram users and the top level circle_portal_wall_collision
package cpw_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_LINES  = 256;
    localparam int ADDR_BITS  = $clog2(MAX_LINES);
    localparam int CNT_BITS   = $clog2(MAX_LINES + 1);
    localparam int EYE_BITS   = 23;
    localparam int CFG_BITS   = 23;

    localparam logic [EYE_BITS-1:0] EYE_RESET = 23'd14336;
    // 24.0 in Q16.8, and log2 of 8.0 squared in the 16-fraction-bit scale of squared Q16.8 distances
    localparam logic signed [COORD_BITS:0] STEP_UP = 25'sd6144;
    localparam int RADIUS_SQ_LOG2 = 22;

    // configuration register indexes
    localparam logic REG_EYE   = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // item kinds carried on tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PROBE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // one table entry
    typedef struct packed {
        logic                         back;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] ff;
        logic signed [COORD_BITS-1:0] fc;
        logic signed [COORD_BITS-1:0] bf;
        logic signed [COORD_BITS-1:0] bc;
    } t_wall;

    localparam int WALL_BITS = $bits(t_wall);

endpackage

// File: hw/rtl/cpw_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module cpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/circle_portal_wall_collision.sv
// Circle-against-wall collision probe over a table of up to 256 wall segments.
// A load beat writes one entry of the segment ram and returns a result beat with
// blocked clear. A probe beat reads entries 0 to line_count-1 from that ram, one
// per cycle, through a six-stage pipeline (ram read, differences, products, sums,
// split square of the cross product, final compare). The result beat waits in an
// output register; a new input beat is taken only while idle and once that
// register is empty or being drained.
// Depends on cpw_pkg and cpw_ram.
module circle_portal_wall_collision
    import cpw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    // fields from bit 0: entry_index[7:0], x_first[31:8], y_first[55:32],
    // x_second[79:56], y_second[103:80], has_back[104], front_floor[128:105],
    // front_ceiling[152:129], back_floor[176:153], back_ceiling[200:177],
    // current_floor[224:201], zero pad
    input  logic [231:0]   s_tdata,
    // fields from bit 0: mode
    input  logic           s_tuser,
    input  logic           s_tvalid,
    output logic           s_tready,
    // fields from bit 0: blocked, zero pad
    output logic [7:0]     m_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  logic           i_cfg_we,
    input  logic           i_cfg_addr,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    localparam int CB = COORD_BITS;

    // input field unpacking
    logic [7:0]           in_index;
    logic signed [CB-1:0] in_xf, in_yf, in_xs, in_ys, in_ff, in_fc, in_bf, in_bc, in_cur;
    logic                 in_back;

    assign in_index = s_tdata[7:0];
    assign in_xf    = s_tdata[31:8];
    assign in_yf    = s_tdata[55:32];
    assign in_xs    = s_tdata[79:56];
    assign in_ys    = s_tdata[103:80];
    assign in_back  = s_tdata[104];
    assign in_ff    = s_tdata[128:105];
    assign in_fc    = s_tdata[152:129];
    assign in_bf    = s_tdata[176:153];
    assign in_bc    = s_tdata[200:177];
    assign in_cur   = s_tdata[224:201];

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // configuration registers
    logic [EYE_BITS-1:0] r_eye;
    logic [CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye   <= EYE_RESET;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_EYE:   r_eye   <= i_cfg_wdata[EYE_BITS-1:0];
                REG_COUNT: r_count <= i_cfg_wdata[CNT_BITS-1:0];
                default:   r_eye   <= r_eye;
            endcase
        end
    end

    logic [CNT_BITS-1:0] lines;
    assign lines = (r_count > CNT_BITS'(MAX_LINES)) ? CNT_BITS'(MAX_LINES) : r_count;

    // segment table
    t_wall wr_wall, rd_wall;
    logic  ram_we;
    logic [CNT_BITS-1:0] r_cnt;

    always_comb begin
        wr_wall.back = in_back;
        wr_wall.ax   = in_xf;
        wr_wall.ay   = in_yf;
        wr_wall.bx   = in_xs;
        wr_wall.by   = in_ys;
        wr_wall.ff   = in_ff;
        wr_wall.fc   = in_fc;
        wr_wall.bf   = in_bf;
        wr_wall.bc   = in_bc;
    end

    assign ram_we = s_fire && (s_tuser == MODE_LOAD);

    cpw_ram #(
        .WIDTH(WALL_BITS),
        .DEPTH(MAX_LINES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(in_index[ADDR_BITS-1:0]),
        .i_wdata(wr_wall),
        .i_raddr(r_cnt[ADDR_BITS-1:0]),
        .o_rdata(rd_wall)
    );

    // control state
    t_state r_state, n_state;
    logic   r_v1, r_v2, r_v3, r_v4, r_v5;
    logic   issue, done;
    logic   r_hit;
    logic   r_m_valid, r_m_blocked;
    logic signed [CB-1:0] r_px, r_py, r_floor;

    assign issue = (r_state == ST_RUN) && (r_cnt < lines);

    always_comb begin
        n_state = r_state;
        done    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_fire && (s_tuser == MODE_PROBE)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!issue && !r_v1 && !r_v2 && !r_v3 && !r_v4 && !r_v5) begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign s_tready = (r_state == ST_IDLE) && (!r_m_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            if (s_fire) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (ram_we || done) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // probe operands and result beat payload
    always_ff @(posedge i_clk) begin
        if (s_fire && (s_tuser == MODE_PROBE)) begin
            r_px    <= in_xf;
            r_py    <= in_yf;
            r_floor <= in_cur;
        end
        if (ram_we) begin
            r_m_blocked <= 1'b0;
        end else if (done) begin
            r_m_blocked <= r_hit;
        end
    end

    // stage 1: differences and height checks
    logic signed [CB:0]   s1_ex, s1_ey, s1_dx, s1_dy, s1_bx, s1_by;
    logic signed [CB-1:0] s1_top, s1_bottom;
    logic signed [CB+1:0] s1_open;
    logic signed [CB:0]   s1_brise, s1_frise;
    logic signed [CB:0]   r2_ex, r2_ey, r2_dx, r2_dy, r2_bx, r2_by;
    logic                 r2_back, r2_short, r2_bstep, r2_fstep;

    always_comb begin
        s1_ex     = {rd_wall.bx[CB-1], rd_wall.bx} - {rd_wall.ax[CB-1], rd_wall.ax};
        s1_ey     = {rd_wall.by[CB-1], rd_wall.by} - {rd_wall.ay[CB-1], rd_wall.ay};
        s1_dx     = {r_px[CB-1], r_px} - {rd_wall.ax[CB-1], rd_wall.ax};
        s1_dy     = {r_py[CB-1], r_py} - {rd_wall.ay[CB-1], rd_wall.ay};
        s1_bx     = {r_px[CB-1], r_px} - {rd_wall.bx[CB-1], rd_wall.bx};
        s1_by     = {r_py[CB-1], r_py} - {rd_wall.by[CB-1], rd_wall.by};
        s1_top    = (rd_wall.fc < rd_wall.bc) ? rd_wall.fc : rd_wall.bc;
        s1_bottom = (rd_wall.ff > rd_wall.bf) ? rd_wall.ff : rd_wall.bf;
        s1_open   = {{2{s1_top[CB-1]}}, s1_top} - {{2{s1_bottom[CB-1]}}, s1_bottom};
        s1_brise  = {rd_wall.bf[CB-1], rd_wall.bf} - {r_floor[CB-1], r_floor};
        s1_frise  = {rd_wall.ff[CB-1], rd_wall.ff} - {r_floor[CB-1], r_floor};
    end

    always_ff @(posedge i_clk) begin
        r2_ex    <= s1_ex;
        r2_ey    <= s1_ey;
        r2_dx    <= s1_dx;
        r2_dy    <= s1_dy;
        r2_bx    <= s1_bx;
        r2_by    <= s1_by;
        r2_back  <= rd_wall.back;
        r2_short <= s1_open < $signed({3'b000, r_eye});
        r2_bstep <= s1_brise > STEP_UP;
        r2_fstep <= s1_frise > STEP_UP;
    end

    // stage 2: products
    localparam int PB = 2 * (CB + 1);
    logic signed [PB-1:0] r3_exx, r3_eyy, r3_dxe, r3_dye, r3_exdy, r3_eydx;
    logic signed [PB-1:0] r3_dxx, r3_dyy, r3_bxx, r3_byy;
    logic                 r3_back, r3_short, r3_bstep, r3_fstep;

    always_ff @(posedge i_clk) begin
        r3_exx   <= r2_ex * r2_ex;
        r3_eyy   <= r2_ey * r2_ey;
        r3_dxe   <= r2_dx * r2_ex;
        r3_dye   <= r2_dy * r2_ey;
        r3_exdy  <= r2_ex * r2_dy;
        r3_eydx  <= r2_ey * r2_dx;
        r3_dxx   <= r2_dx * r2_dx;
        r3_dyy   <= r2_dy * r2_dy;
        r3_bxx   <= r2_bx * r2_bx;
        r3_byy   <= r2_by * r2_by;
        r3_back  <= r2_back;
        r3_short <= r2_short;
        r3_bstep <= r2_bstep;
        r3_fstep <= r2_fstep;
    end

    // stage 3: sums and point-distance checks
    localparam int SB = PB + 1;
    logic signed [SB-1:0] s3_l2, s3_dot, s3_cross, s3_na, s3_nb;
    logic signed [SB-1:0] r4_l2, r4_dot;
    logic [SB-2:0]        r4_mag;
    logic                 r4_near_a, r4_near_b, r4_cpos;
    logic                 r4_back, r4_short, r4_bstep, r4_fstep;

    always_comb begin
        s3_l2    = {r3_exx[PB-1], r3_exx} + {r3_eyy[PB-1], r3_eyy};
        s3_dot   = {r3_dxe[PB-1], r3_dxe} + {r3_dye[PB-1], r3_dye};
        s3_cross = {r3_exdy[PB-1], r3_exdy} - {r3_eydx[PB-1], r3_eydx};
        s3_na    = {r3_dxx[PB-1], r3_dxx} + {r3_dyy[PB-1], r3_dyy};
        s3_nb    = {r3_bxx[PB-1], r3_bxx} + {r3_byy[PB-1], r3_byy};
    end

    always_ff @(posedge i_clk) begin
        r4_l2     <= s3_l2;
        r4_dot    <= s3_dot;
        r4_mag    <= s3_cross[SB-1] ? (SB-1)'(-s3_cross) : s3_cross[SB-2:0];
        r4_cpos   <= (s3_cross > 0);
        r4_near_a <= s3_na < (SB'(1) <<< RADIUS_SQ_LOG2);
        r4_near_b <= s3_nb < (SB'(1) <<< RADIUS_SQ_LOG2);
        r4_back   <= r3_back;
        r4_short  <= r3_short;
        r4_bstep  <= r3_bstep;
        r4_fstep  <= r3_fstep;
    end

    // stage 4: split square of the cross magnitude, range checks
    localparam int MB = SB - 1;
    localparam int LB = (MB + 1) / 2;
    localparam int HB = MB - LB;
    logic [2*HB-1:0]    r5_hh;
    logic [HB+LB-1:0]   r5_hl;
    logic [2*LB-1:0]    r5_ll;
    logic [SB-2:0]      r5_l2;
    logic               r5_low, r5_high, r5_near_a, r5_near_b, r5_cpos;
    logic               r5_back, r5_short, r5_bstep, r5_fstep;

    always_ff @(posedge i_clk) begin
        r5_hh     <= r4_mag[MB-1:LB] * r4_mag[MB-1:LB];
        r5_hl     <= r4_mag[MB-1:LB] * r4_mag[LB-1:0];
        r5_ll     <= r4_mag[LB-1:0] * r4_mag[LB-1:0];
        r5_l2     <= r4_l2[SB-2:0];
        r5_low    <= (r4_l2 == '0) || (r4_dot <= 0);
        r5_high   <= (r4_dot >= r4_l2);
        r5_near_a <= r4_near_a;
        r5_near_b <= r4_near_b;
        r5_cpos   <= r4_cpos;
        r5_back   <= r4_back;
        r5_short  <= r4_short;
        r5_bstep  <= r4_bstep;
        r5_fstep  <= r4_fstep;
    end

    // stage 5: final compare and blocking decision
    localparam int QB = 2 * MB + 1;
    logic [QB-1:0] s5_csq, s5_lim;
    logic          s5_touch, s5_block;

    always_comb begin
        s5_csq = (QB'(r5_hh) << (2 * LB)) + (QB'(r5_hl) << (LB + 1)) + QB'(r5_ll);
        s5_lim = QB'(r5_l2) << RADIUS_SQ_LOG2;
        if (r5_low) begin
            s5_touch = r5_near_a;
        end else if (r5_high) begin
            s5_touch = r5_near_b;
        end else begin
            s5_touch = s5_csq < s5_lim;
        end
        s5_block = !r5_back || r5_short || (r5_cpos ? r5_bstep : r5_fstep);
    end

    // sticky hit over one probe
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_hit <= 1'b0;
        end else if (r_v5 && s5_touch && s5_block) begin
            r_hit <= 1'b1;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {7'b0, r_m_blocked};

endmodule
